FILE: rtl/bdpq_pkg.sv
// shared constants, types and helpers for the palette quantizer
`timescale 1ns / 1ps
package bdpq_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int NUM_LANES = 16;
    localparam int LANE_DEPTH = PALETTE_DEPTH / NUM_LANES;
    localparam int LANE_AW = (LANE_DEPTH > 1) ? $clog2(LANE_DEPTH) : 1;
    localparam int LANE_SW = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;
    localparam int IDX_W = 8;
    localparam int SIZE_W = 9;
    localparam int COLOR_W = 24;
    localparam int DIST_W = 18;
    localparam int SLOT_W = LANE_AW + 1;
    localparam int SEARCH_W = (PALETTE_DEPTH < 256) ? PALETTE_DEPTH : 256;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CONVERT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_MERGE
    } state_t;

    typedef struct packed {
        logic             active;
        logic [LANE_AW-1:0] addr;
        logic [8:0]        base;
    } lane_ctl_t;

    function automatic logic [15:0] sq8(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] d;
        begin
            d = (a > b) ? (a - b) : (b - a);
            sq8 = 16'(d) * 16'(d);
        end
    endfunction

endpackage

FILE: rtl/box_downscale_palette_quantizer_top.sv
// top level of the 2x2 box downscale palette quantizer
`timescale 1ns / 1ps
// A convert transaction keeps busy high while it scans the 16 palette banks in
// parallel (one entry per bank per cycle), drains the bank read and distance
// registers, and merges the lane results one lane per cycle in index order.
// done then pulses for one cycle with nearest_index in the first cycle that
// busy is low again, and a new start may be accepted in that same cycle. A
// palette write is accepted while idle, leaves busy low and gives no result.
// Results cannot be held off by the receiver.
module box_downscale_palette_quantizer_top import bdpq_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               operation,
    input  logic [7:0]         entry_index,
    input  logic [23:0]        entry_color,
    input  logic [23:0]        pixel_top_left,
    input  logic [23:0]        pixel_top_right,
    input  logic [23:0]        pixel_bottom_left,
    input  logic [23:0]        pixel_bottom_right,
    input  logic               cfg_we,
    input  logic [8:0]         cfg_wdata,
    output logic               done,
    output logic [7:0]         nearest_index
);
    state_t state_reg, state_next;
    logic [SIZE_W-1:0]  size_reg;
    logic [LANE_AW-1:0] addr_reg, addr_next;
    logic [LANE_SW:0]   cnt_reg, cnt_next;
    logic [7:0]         avg0_reg, avg1_reg, avg2_reg;
    logic [SIZE_W-1:0]  limit;
    logic               accept;
    logic               scan_last;
    logic               clear;
    lane_ctl_t          ctl [NUM_LANES];
    logic               lf [NUM_LANES];
    logic [DIST_W-1:0]  ld [NUM_LANES];
    logic [8:0]         li [NUM_LANES];
    logic               mf_reg;
    logic [DIST_W-1:0]  md_reg;
    logic [7:0]         mi_reg;
    logic               done_reg;
    logic [7:0]         out_reg;
    logic [LANE_SW-1:0] sel;

    assign accept = start && !busy;
    assign limit = (size_reg > SIZE_W'(SEARCH_W)) ? SIZE_W'(SEARCH_W) : size_reg;
    assign clear = accept && operation == OP_CONVERT;
    assign scan_last = addr_reg == LANE_AW'(LANE_DEPTH - 1);
    assign sel = cnt_reg[LANE_SW-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (clear) state_next = ST_SCAN;
            ST_SCAN:  if (scan_last) state_next = ST_DRAIN;
            ST_DRAIN: if (cnt_reg == (LANE_SW+1)'(1)) state_next = ST_MERGE;
            ST_MERGE: if (cnt_reg == (LANE_SW+1)'(NUM_LANES - 1)) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        addr_next = addr_reg;
        cnt_next = cnt_reg;
        case (state_reg)
            ST_IDLE:  begin addr_next = '0; cnt_next = '0; end
            ST_SCAN:  begin addr_next = addr_reg + 1'b1; cnt_next = '0; end
            ST_DRAIN: cnt_next = (cnt_reg == (LANE_SW+1)'(1)) ? '0 : cnt_reg + 1'b1;
            ST_MERGE: cnt_next = cnt_reg + 1'b1;
            default:  cnt_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            size_reg <= SIZE_RESET;
            addr_reg <= '0;
            cnt_reg <= '0;
            done_reg <= 1'b0;
            mf_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg <= addr_next;
            cnt_reg <= cnt_next;
            if (cfg_we)
                size_reg <= cfg_wdata;
            done_reg <= state_reg == ST_MERGE && state_next == ST_IDLE;
            if (state_reg == ST_DRAIN)
                mf_reg <= 1'b0;
            else if (state_reg == ST_MERGE && lf[sel] && (!mf_reg || ld[sel] < md_reg))
                mf_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clear)
        begin
            avg0_reg <= 8'((10'(pixel_top_left[7:0]) + 10'(pixel_top_right[7:0])
                + 10'(pixel_bottom_left[7:0]) + 10'(pixel_bottom_right[7:0])) >> 2);
            avg1_reg <= 8'((10'(pixel_top_left[15:8]) + 10'(pixel_top_right[15:8])
                + 10'(pixel_bottom_left[15:8]) + 10'(pixel_bottom_right[15:8])) >> 2);
            avg2_reg <= 8'((10'(pixel_top_left[23:16]) + 10'(pixel_top_right[23:16])
                + 10'(pixel_bottom_left[23:16]) + 10'(pixel_bottom_right[23:16])) >> 2);
        end
        if (state_reg == ST_DRAIN)
            mi_reg <= '0;
        else if (state_reg == ST_MERGE && lf[sel] && (!mf_reg || ld[sel] < md_reg))
        begin
            md_reg <= ld[sel];
            mi_reg <= li[sel][7:0];
        end
        if (state_reg == ST_MERGE && state_next == ST_IDLE)
            out_reg <= (lf[sel] && (!mf_reg || ld[sel] < md_reg)) ? li[sel][7:0] : mi_reg;
    end

    // entry i lives in bank i / LANE_DEPTH at i % LANE_DEPTH, so lanes merge in index order
    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        assign ctl[g].active = state_reg == ST_SCAN;
        assign ctl[g].addr = addr_reg;
        assign ctl[g].base = 9'(g * LANE_DEPTH);
        bdpq_lane u_lane (
            .clk(clk), .rst_n(rst_n),
            .we(accept && operation == OP_WRITE
                && entry_index[7:LANE_AW] == (8 - LANE_AW)'(g)),
            .waddr(entry_index[LANE_AW-1:0]), .wdata(entry_color),
            .clear(clear), .ctl(ctl[g]), .limit(limit),
            .avg0(avg0_reg), .avg1(avg1_reg), .avg2(avg2_reg),
            .found(lf[g]), .best_dist(ld[g]), .best_idx(li[g])
        );
    end

    assign busy = state_reg != ST_IDLE;
    assign done = done_reg;
    assign nearest_index = out_reg;
endmodule

FILE: rtl/bdpq_ram.sv
// generic ram with separate write and read ports and registered read
`timescale 1ns / 1ps
module bdpq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/bdpq_lane.sv
// one search lane: palette bank, distance unit and running minimum
`timescale 1ns / 1ps
module bdpq_lane import bdpq_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               we,
    input  logic [LANE_AW-1:0] waddr,
    input  logic [COLOR_W-1:0] wdata,
    input  logic               clear,
    input  lane_ctl_t          ctl,
    input  logic [SIZE_W-1:0]  limit,
    input  logic [7:0]         avg0,
    input  logic [7:0]         avg1,
    input  logic [7:0]         avg2,
    output logic               found,
    output logic [DIST_W-1:0]  best_dist,
    output logic [8:0]         best_idx
);
    logic [COLOR_W-1:0] rdata;
    logic               v_reg;
    logic [8:0]         idx_reg;
    logic [DIST_W-1:0]  d;
    logic               take;
    logic               found_reg;
    logic [DIST_W-1:0]  dist_reg;
    logic [8:0]         bidx_reg;

    bdpq_ram #(.WIDTH(COLOR_W), .DEPTH(LANE_DEPTH)) u_bank (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(ctl.addr), .rdata(rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            v_reg <= ctl.active && (ctl.base + 9'(ctl.addr) < limit);
            if (clear)
                found_reg <= 1'b0;
            else if (take)
                found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= ctl.base + 9'(ctl.addr);
        if (take)
        begin
            dist_reg <= d;
            bidx_reg <= idx_reg;
        end
    end

    // channel 2 against byte 0, channel 0 against byte 2
    assign d = DIST_W'(sq8(avg2, rdata[7:0])) + DIST_W'(sq8(avg1, rdata[15:8]))
             + DIST_W'(sq8(avg0, rdata[23:16]));
    assign take = v_reg && !clear && (!found_reg || d < dist_reg);

    assign found = found_reg;
    assign best_dist = dist_reg;
    assign best_idx = bidx_reg;
endmodule

FILE: rtl/bdpq_checker.sv
// port level checks for the palette quantizer
`timescale 1ns / 1ps
module bdpq_props (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic operation,
    input logic done
);
    a_conv_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && operation |=> busy) else $error("convert did not go busy");
    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !operation |=> !busy) else $error("write made block busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done longer than one cycle");
    a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy)) else $error("done outside end of transaction");
endmodule

bind box_downscale_palette_quantizer_top bdpq_props u_bdpq_props (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .operation(operation), .done(done)
);
